// File: design/multichannel_conv2d_same_bias_top_macros.svh
// Assertion macros for the convolution block
`ifndef MULTICHANNEL_CONV2D_SAME_BIAS_TOP_MACROS_SVH
`define MULTICHANNEL_CONV2D_SAME_BIAS_TOP_MACROS_SVH
`ifndef ASSERT_OFF
`define CHK_IMPL(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("check failed");
`define CHK_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("check failed");
`else
`define CHK_IMPL(label, clk, rst_n, ante, cons)
`define CHK_NEXT(label, clk, rst_n, ante, cons)
`endif
`endif

// File: design/mcconv_pkg.sv
// ----------------------------------------------------------------------------
// mcconv_pkg
// Shared types and codes of the convolution block.
// ----------------------------------------------------------------------------
package mcconv_pkg;
    localparam int DEF_MAX_WIDTH    = 32;
    localparam int DEF_MAX_HEIGHT   = 32;
    localparam int DEF_MAX_CHANNELS = 32;
    localparam int DEF_MAX_FILTERS  = 64;
    localparam int DEF_MAX_KERNEL   = 5;

    localparam logic [1:0] REQ_SAMPLE  = 2'd0;
    localparam logic [1:0] REQ_WEIGHT  = 2'd1;
    localparam logic [1:0] REQ_BIAS    = 2'd2;
    localparam logic [1:0] REQ_COMPUTE = 2'd3;

    localparam logic [2:0] CFG_WIDTH    = 3'd0;
    localparam logic [2:0] CFG_HEIGHT   = 3'd1;
    localparam logic [2:0] CFG_CHANNELS = 3'd2;
    localparam logic [2:0] CFG_FILTERS  = 3'd3;
    localparam logic [2:0] CFG_KERNEL   = 3'd4;

    // controller to datapath
    typedef struct packed {
        logic load;     // capture the request
        logic start;    // load bias, clear tap counters
        logic step;     // issue one tap
        logic finish;   // saturate and latch result
    } dp_cmd_t;

    // datapath to controller
    typedef struct packed {
        logic is_compute;
        logic bad;
        logic last_tap;
        logic drained;
    } dp_stat_t;
endpackage

// File: design/mcconv_ctrl.sv
// ----------------------------------------------------------------------------
// mcconv_ctrl
// Sequencer: accept, run taps, drain pipeline, present result.
// ----------------------------------------------------------------------------
`include "multichannel_conv2d_same_bias_top_macros.svh"
module mcconv_ctrl (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_stall,
    output logic                out_valid,
    input  logic                out_stall,
    output mcconv_pkg::dp_cmd_t cmd,
    input  mcconv_pkg::dp_stat_t stat
);
    import mcconv_pkg::*;

    typedef enum logic [4:0] {
        ST_IDLE  = 5'b00001,
        ST_DEC   = 5'b00010,
        ST_RUN   = 5'b00100,
        ST_DRAIN = 5'b01000,
        ST_FIN   = 5'b10000
    } state_t;

    state_t state_reg, state_next;
    logic   out_valid_reg, out_valid_next;

    // accept while idle, even with a result still waiting
    assign in_stall  = (state_reg != ST_IDLE);
    assign out_valid = out_valid_reg;

    always_comb
    begin
        state_next     = state_reg;
        out_valid_next = out_valid_reg;
        cmd            = '0;
        if (out_valid_reg && !out_stall)
        begin
            out_valid_next = 1'b0;
        end
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.load   = 1'b1;
                    state_next = ST_DEC;
                end
            end
            ST_DEC:
            begin
                if (stat.is_compute && !stat.bad)
                begin
                    cmd.start  = 1'b1;
                    state_next = ST_RUN;
                end
                else
                begin
                    state_next = ST_FIN;
                end
            end
            ST_RUN:
            begin
                cmd.step = 1'b1;
                if (stat.last_tap)
                begin
                    state_next = ST_DRAIN;
                end
            end
            ST_DRAIN:
            begin
                if (stat.drained)
                begin
                    state_next = ST_FIN;
                end
            end
            ST_FIN:
            begin
                // wait for the output register to be free
                if (!out_valid_next)
                begin
                    cmd.finish     = 1'b1;
                    out_valid_next = 1'b1;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    `CHK_NEXT(a_load_leaves_idle, clk, rst_n, cmd.load, state_reg == ST_DEC)
    `CHK_IMPL(a_finish_one, clk, rst_n, cmd.finish, !(out_valid_reg && out_stall))
    `CHK_IMPL(a_step_only_run, clk, rst_n, cmd.step, state_reg == ST_RUN)
    `CHK_NEXT(a_finish_valid, clk, rst_n, cmd.finish, out_valid_reg)
endmodule

// File: design/mcconv_dp.sv
// ----------------------------------------------------------------------------
// mcconv_dp
// Stores, tap counters, one multiply-accumulate per cycle, saturation.
// ----------------------------------------------------------------------------
module mcconv_dp #(
    parameter int MAX_WIDTH    = mcconv_pkg::DEF_MAX_WIDTH,
    parameter int MAX_HEIGHT   = mcconv_pkg::DEF_MAX_HEIGHT,
    parameter int MAX_CHANNELS = mcconv_pkg::DEF_MAX_CHANNELS,
    parameter int MAX_FILTERS  = mcconv_pkg::DEF_MAX_FILTERS,
    parameter int MAX_KERNEL   = mcconv_pkg::DEF_MAX_KERNEL
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cfg_we,
    input  logic [2:0]           cfg_addr,
    input  logic [6:0]           cfg_wdata,
    input  logic [1:0]           req_type,
    input  logic [5:0]           filter_index,
    input  logic [4:0]           channel,
    input  logic [4:0]           row,
    input  logic [4:0]           col,
    input  logic [2:0]           tap_row,
    input  logic [2:0]           tap_col,
    input  logic signed [15:0]   sample_value,
    input  logic signed [31:0]   bias_value,
    input  mcconv_pkg::dp_cmd_t  cmd,
    output mcconv_pkg::dp_stat_t stat,
    output logic signed [31:0]   conv_out,
    output logic                 saturated,
    output logic                 bad_index
);
    import mcconv_pkg::*;

    localparam int XB   = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
    localparam int YB   = (MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1;
    localparam int PB   = (MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1;
    localparam int QB   = (MAX_FILTERS > 1) ? $clog2(MAX_FILTERS) : 1;
    localparam int TB   = (MAX_KERNEL > 1) ? $clog2(MAX_KERNEL) : 1;
    localparam int IMGD = MAX_CHANNELS * MAX_HEIGHT * MAX_WIDTH;
    localparam int WGTD = MAX_FILTERS * MAX_CHANNELS * MAX_KERNEL * MAX_KERNEL;
    localparam int IAB  = (IMGD > 1) ? $clog2(IMGD) : 1;
    localparam int WAB  = (WGTD > 1) ? $clog2(WGTD) : 1;
    localparam int SB   = 8;   // signed position width, covers -5..31+5
    localparam int ACCB = 48;

    // configuration
    logic [5:0] w_reg, h_reg, nc_reg, k_ext;
    logic [6:0] nf_reg;
    logic [2:0] k_reg;
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            w_reg  <= 6'd32;
            h_reg  <= 6'd32;
            nc_reg <= 6'd3;
            nf_reg <= 7'd32;
            k_reg  <= 3'd3;
        end
        else if (cfg_we)
        begin
            unique case (cfg_addr)
                CFG_WIDTH:    w_reg  <= cfg_wdata[5:0];
                CFG_HEIGHT:   h_reg  <= cfg_wdata[5:0];
                CFG_CHANNELS: nc_reg <= cfg_wdata[5:0];
                CFG_FILTERS:  nf_reg <= cfg_wdata;
                CFG_KERNEL:   k_reg  <= cfg_wdata[2:0];
                default:      ;
            endcase
        end
    end
    assign k_ext = {3'd0, k_reg};

    // effective sizes, held in 32-bit compare space
    logic [31:0] ew, eh, enc, enf, ek;
    assign ew  = (32'(w_reg)  > 32'(MAX_WIDTH))    ? 32'(MAX_WIDTH)    : 32'(w_reg);
    assign eh  = (32'(h_reg)  > 32'(MAX_HEIGHT))   ? 32'(MAX_HEIGHT)   : 32'(h_reg);
    assign enc = (32'(nc_reg) > 32'(MAX_CHANNELS)) ? 32'(MAX_CHANNELS) : 32'(nc_reg);
    assign enf = (32'(nf_reg) > 32'(MAX_FILTERS))  ? 32'(MAX_FILTERS)  : 32'(nf_reg);
    assign ek  = (32'(k_ext)  > 32'(MAX_KERNEL))   ? 32'(MAX_KERNEL)   : 32'(k_ext);

    // captured request
    logic [1:0]         rq_reg;
    logic [5:0]         f_reg;
    logic [4:0]         ch_reg, r_reg, c_reg;
    logic [2:0]         tr_reg, tc_reg;
    logic signed [15:0] sv_reg;
    logic signed [31:0] bv_reg;
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            rq_reg <= req_type;
            f_reg  <= filter_index;
            ch_reg <= channel;
            r_reg  <= row;
            c_reg  <= col;
            tr_reg <= tap_row;
            tc_reg <= tap_col;
            sv_reg <= sample_value;
            bv_reg <= bias_value;
        end
    end

    logic ok_f, ok_c, ok_r, ok_col, ok_t, bad;
    assign ok_f   = 32'(f_reg) < enf;
    assign ok_c   = 32'(ch_reg) < enc;
    assign ok_r   = 32'(r_reg) < eh;
    assign ok_col = 32'(c_reg) < ew;
    assign ok_t   = (32'(tr_reg) < ek) && (32'(tc_reg) < ek);
    always_comb
    begin
        unique case (rq_reg)
            REQ_SAMPLE: bad = !(ok_c && ok_r && ok_col);
            REQ_WEIGHT: bad = !(ok_f && ok_c && ok_t);
            REQ_BIAS:   bad = !ok_f;
            default:    bad = !(ok_f && ok_r && ok_col);
        endcase
    end

    // write pulse in the decode cycle: cmd.load, registered
    logic dec_reg;
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            dec_reg <= 1'b0;
        else
            dec_reg <= cmd.load;
    end

    logic [IAB-1:0] img_waddr;
    logic [WAB-1:0] wgt_waddr;
    assign img_waddr = IAB'(((32'(ch_reg) * MAX_HEIGHT) + 32'(r_reg)) * MAX_WIDTH + 32'(c_reg));
    assign wgt_waddr = WAB'((((32'(f_reg) * MAX_CHANNELS + 32'(ch_reg)) * MAX_KERNEL
                           + 32'(tr_reg)) * MAX_KERNEL) + 32'(tc_reg));

    // tap counters
    logic [PB-1:0] p_reg;
    logic [TB-1:0] a_reg, b_reg;
    logic          last;
    assign last = (32'(p_reg) + 1 >= enc) && (32'(a_reg) + 1 >= ek) && (32'(b_reg) + 1 >= ek);
    always_ff @(posedge clk)
    begin
        if (cmd.start)
        begin
            p_reg <= '0;
            a_reg <= '0;
            b_reg <= '0;
        end
        else if (cmd.step)
        begin
            if (32'(b_reg) + 1 < ek)
                b_reg <= b_reg + 1'b1;
            else
            begin
                b_reg <= '0;
                if (32'(a_reg) + 1 < ek)
                    a_reg <= a_reg + 1'b1;
                else
                begin
                    a_reg <= '0;
                    p_reg <= p_reg + 1'b1;
                end
            end
        end
    end

    // tap position and validity
    logic signed [SB-1:0] rr, cc, half;
    logic                 tap_ok;
    assign half   = SB'(ek >> 1);
    assign rr     = $signed({3'd0, r_reg}) + $signed(SB'(a_reg)) - half;
    assign cc     = $signed({3'd0, c_reg}) + $signed(SB'(b_reg)) - half;
    assign tap_ok = (rr >= 0) && (32'(rr) < eh) && (cc >= 0) && (32'(cc) < ew)
                  && (enc != 0) && (ek != 0);

    logic [IAB-1:0] img_raddr;
    logic [WAB-1:0] wgt_raddr;
    assign img_raddr = IAB'(((32'(p_reg) * MAX_HEIGHT) + 32'(rr[YB-1:0])) * MAX_WIDTH
                       + 32'(cc[XB-1:0]));
    assign wgt_raddr = WAB'((((32'(f_reg) * MAX_CHANNELS + 32'(p_reg)) * MAX_KERNEL
                           + 32'(a_reg)) * MAX_KERNEL) + 32'(b_reg));

    // stores
    logic signed [15:0] image_mem [IMGD];
    logic signed [15:0] weight_mem [WGTD];
    logic signed [31:0] bias_mem [MAX_FILTERS];
    logic signed [15:0] img_q_reg, wgt_q_reg;
    logic signed [31:0] bias_q_reg;
    always_ff @(posedge clk)
    begin
        if (dec_reg && !bad && rq_reg == REQ_SAMPLE)
            image_mem[img_waddr] <= sv_reg;
        img_q_reg <= image_mem[img_raddr];
    end
    always_ff @(posedge clk)
    begin
        if (dec_reg && !bad && rq_reg == REQ_WEIGHT)
            weight_mem[wgt_waddr] <= sv_reg;
        wgt_q_reg <= weight_mem[wgt_raddr];
    end
    always_ff @(posedge clk)
    begin
        if (dec_reg && !bad && rq_reg == REQ_BIAS)
            bias_mem[f_reg[QB-1:0]] <= bv_reg;
        bias_q_reg <= bias_mem[f_reg[QB-1:0]];
    end

    // pipeline: read -> multiply -> accumulate
    logic                 v1_reg, v2_reg, bias_ld_reg;
    logic signed [31:0]   prod_reg;
    logic signed [ACCB-1:0] acc_reg;
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg      <= 1'b0;
            v2_reg      <= 1'b0;
            bias_ld_reg <= 1'b0;
        end
        else
        begin
            v1_reg      <= cmd.step && tap_ok;
            v2_reg      <= v1_reg;
            bias_ld_reg <= cmd.start;
        end
    end
    always_ff @(posedge clk)
    begin
        prod_reg <= img_q_reg * wgt_q_reg;
        if (bias_ld_reg)
            acc_reg <= ACCB'(bias_q_reg);
        else if (v2_reg)
            acc_reg <= acc_reg + ACCB'(prod_reg);
    end

    // result
    logic signed [31:0] res_reg;
    logic               sat_reg, bad_reg;
    always_ff @(posedge clk)
    begin
        if (cmd.finish)
        begin
            bad_reg <= bad;
            if (bad || rq_reg != REQ_COMPUTE)
            begin
                res_reg <= '0;
                sat_reg <= 1'b0;
            end
            else if (acc_reg > ACCB'(32'sh7fffffff))
            begin
                res_reg <= 32'sh7fffffff;
                sat_reg <= 1'b1;
            end
            else if (acc_reg < -ACCB'(33'sh080000000))
            begin
                res_reg <= 32'sh80000000;
                sat_reg <= 1'b1;
            end
            else
            begin
                res_reg <= acc_reg[31:0];
                sat_reg <= 1'b0;
            end
        end
    end

    assign conv_out  = res_reg;
    assign saturated = sat_reg;
    assign bad_index = bad_reg;

    assign stat.is_compute = (rq_reg == REQ_COMPUTE);
    assign stat.bad        = bad;
    assign stat.last_tap   = last;
    assign stat.drained    = !v1_reg && !v2_reg && !cmd.step;
endmodule

// File: design/multichannel_conv2d_same_bias_top.sv
// Requests are handled one at a time; the next can be taken in the cycle the result
// is presented. An in-range compute issues S = nc*K*K tap steps, a zero count or
// side taken as one.
// Reset: asynchronous rst_n resets control and the size registers; stores are not cleared.
// ----------------------------------------------------------------------------
// multichannel_conv2d_same_bias_top
// Multichannel same-size convolution with bias, fixed point.
// ----------------------------------------------------------------------------
module multichannel_conv2d_same_bias_top #(
    parameter int MAX_WIDTH    = mcconv_pkg::DEF_MAX_WIDTH,
    parameter int MAX_HEIGHT   = mcconv_pkg::DEF_MAX_HEIGHT,
    parameter int MAX_CHANNELS = mcconv_pkg::DEF_MAX_CHANNELS,
    parameter int MAX_FILTERS  = mcconv_pkg::DEF_MAX_FILTERS,
    parameter int MAX_KERNEL   = mcconv_pkg::DEF_MAX_KERNEL
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               cfg_we,
    input  logic [2:0]         cfg_addr,
    input  logic [6:0]         cfg_wdata,
    input  logic               in_valid,
    output logic               in_stall,
    input  logic [1:0]         req_type,
    input  logic [5:0]         filter_index,
    input  logic [4:0]         channel,
    input  logic [4:0]         row,
    input  logic [4:0]         col,
    input  logic [2:0]         tap_row,
    input  logic [2:0]         tap_col,
    input  logic signed [15:0] sample_value,
    input  logic signed [31:0] bias_value,
    output logic               out_valid,
    input  logic               out_stall,
    output logic signed [31:0] conv_out,
    output logic               saturated,
    output logic               bad_index
);
    import mcconv_pkg::*;

    dp_cmd_t  cmd;
    dp_stat_t stat;

    mcconv_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .cmd       (cmd),
        .stat      (stat)
    );

    mcconv_dp #(
        .MAX_WIDTH    (MAX_WIDTH),
        .MAX_HEIGHT   (MAX_HEIGHT),
        .MAX_CHANNELS (MAX_CHANNELS),
        .MAX_FILTERS  (MAX_FILTERS),
        .MAX_KERNEL   (MAX_KERNEL)
    ) u_dp (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_we       (cfg_we),
        .cfg_addr     (cfg_addr),
        .cfg_wdata    (cfg_wdata),
        .req_type     (req_type),
        .filter_index (filter_index),
        .channel      (channel),
        .row          (row),
        .col          (col),
        .tap_row      (tap_row),
        .tap_col      (tap_col),
        .sample_value (sample_value),
        .bias_value   (bias_value),
        .cmd          (cmd),
        .stat         (stat),
        .conv_out     (conv_out),
        .saturated    (saturated),
        .bad_index    (bad_index)
    );
endmodule

// File: sim/multichannel_conv2d_same_bias_top_tb.sv
// ----------------------------------------------------------------------------
// multichannel_conv2d_same_bias_top_tb
// Self-checking bench for the fixed-point same-size convolution layer. Load
// and compute requests are queued per configuration phase. A compute is always
// preceded by writes that fill every store entry it reads. Both handshake sides
// idle at random, and each result is checked against a local prediction.
// ----------------------------------------------------------------------------
module multichannel_conv2d_same_bias_top_tb;
    import mcconv_pkg::*;

    localparam int MW = 32, MH = 32, MC = 32, MF = 64, MK = 5;
    localparam longint CYCLE_LIMIT = 3000000;

    typedef struct {
        logic [1:0]         req;
        logic [5:0]         f;
        logic [4:0]         ch;
        logic [4:0]         r;
        logic [4:0]         c;
        logic [2:0]         tr;
        logic [2:0]         tc;
        logic signed [15:0] sv;
        logic signed [31:0] bv;
    } conv_req_t;

    typedef struct {
        logic signed [31:0] val;
        logic               sat;
        logic               bad;
    } conv_res_t;

    logic               clk = 1'b0;
    logic               rst_n = 1'b0;
    logic               cfg_we = 1'b0;
    logic [2:0]         cfg_addr = '0;
    logic [6:0]         cfg_wdata = '0;
    logic               in_valid = 1'b0;
    logic               in_stall;
    logic [1:0]         req_type = REQ_SAMPLE;
    logic [5:0]         filter_index = '0;
    logic [4:0]         channel = '0;
    logic [4:0]         row = '0;
    logic [4:0]         col = '0;
    logic [2:0]         tap_row = '0;
    logic [2:0]         tap_col = '0;
    logic signed [15:0] sample_value = '0;
    logic signed [31:0] bias_value = '0;
    logic               out_valid;
    logic               out_stall = 1'b0;
    logic signed [31:0] conv_out;
    logic               saturated;
    logic               bad_index;

    multichannel_conv2d_same_bias_top dut (.*);

    always #5 clk = ~clk;

    // Register copies, store copies and the written-entry map used by the generator
    logic [6:0]         cfg_reg [5];
    logic signed [15:0] img_mem [MC*MH*MW];
    logic signed [15:0] wgt_mem [MF*MC*MK*MK];
    logic signed [31:0] bias_mem [MF];
    bit                 img_set [MC*MH*MW];
    bit                 wgt_set [MF*MC*MK*MK];
    bit                 bias_set [MF];

    conv_req_t pending_reqs [$];
    conv_res_t expected_res [$];
    int        err_count = 0;
    longint    cycles = 0;

    function automatic int eff(int idx);
        int v, hi;
        case (idx)
            CFG_WIDTH:    begin v = cfg_reg[idx] & 7'h3f; hi = MW; end
            CFG_HEIGHT:   begin v = cfg_reg[idx] & 7'h3f; hi = MH; end
            CFG_CHANNELS: begin v = cfg_reg[idx] & 7'h3f; hi = MC; end
            CFG_FILTERS:  begin v = cfg_reg[idx]; hi = MF; end
            default:      begin v = cfg_reg[idx] & 7'h07; hi = MK; end
        endcase
        return (v > hi) ? hi : v;
    endfunction

    function automatic int img_at(int ch, int r, int c);
        return (ch * MH + r) * MW + c;
    endfunction

    function automatic int wgt_at(int f, int ch, int tr, int tc);
        return ((f * MC + ch) * MK + tr) * MK + tc;
    endfunction

    function automatic bit req_in_range(conv_req_t q);
        case (q.req)
            REQ_SAMPLE: return q.ch < eff(CFG_CHANNELS) && q.r < eff(CFG_HEIGHT)
                               && q.c < eff(CFG_WIDTH);
            REQ_WEIGHT: return q.f < eff(CFG_FILTERS) && q.ch < eff(CFG_CHANNELS)
                               && q.tr < eff(CFG_KERNEL) && q.tc < eff(CFG_KERNEL);
            REQ_BIAS:   return q.f < eff(CFG_FILTERS);
            default:    return q.f < eff(CFG_FILTERS) && q.r < eff(CFG_HEIGHT)
                               && q.c < eff(CFG_WIDTH);
        endcase
    endfunction

    // Apply one accepted request to the store copies and work out its result
    function automatic conv_res_t conv_predict(conv_req_t q);
        conv_res_t res;
        longint acc;
        int k, half, rr, cc;
        res = '{val: '0, sat: 1'b0, bad: 1'b0};
        if (!req_in_range(q)) begin
            res.bad = 1'b1;
            return res;
        end
        case (q.req)
            REQ_SAMPLE: img_mem[img_at(q.ch, q.r, q.c)] = q.sv;
            REQ_WEIGHT: wgt_mem[wgt_at(q.f, q.ch, q.tr, q.tc)] = q.sv;
            REQ_BIAS:   bias_mem[q.f] = q.bv;
            default:
            begin
                k = eff(CFG_KERNEL);
                half = k / 2;
                acc = bias_mem[q.f];
                for (int p = 0; p < eff(CFG_CHANNELS); p++)
                    for (int a = 0; a < k; a++)
                        for (int b = 0; b < k; b++)
                        begin
                            rr = q.r + a - half;
                            cc = q.c + b - half;
                            if (rr >= 0 && rr < eff(CFG_HEIGHT) && cc >= 0 && cc < eff(CFG_WIDTH))
                                acc += longint'(img_mem[img_at(p, rr, cc)])
                                     * longint'(wgt_mem[wgt_at(q.f, p, a, b)]);
                        end
                if (acc > 64'sd2147483647) begin acc = 64'sd2147483647; res.sat = 1'b1; end
                else if (acc < -64'sd2147483648) begin acc = -64'sd2147483648; res.sat = 1'b1; end
                res.val = acc[31:0];
            end
        endcase
        return res;
    endfunction

    function automatic logic signed [15:0] pick_q88();
        case ($urandom_range(0, 4))
            0:       return 16'sh7fff;
            1:       return -16'sh8000;
            2:       return 16'($urandom_range(0, 1023)) - 16'd512;
            default: return 16'($urandom);
        endcase
    endfunction

    function automatic conv_req_t blank_req(logic [1:0] kind);
        conv_req_t q;
        q = '{req: kind, f: '0, ch: '0, r: '0, c: '0, tr: '0, tc: '0,
              sv: pick_q88(), bv: $urandom};
        return q;
    endfunction

    task automatic queue_write(conv_req_t q);
        if (req_in_range(q))
            case (q.req)
                REQ_SAMPLE: img_set[img_at(q.ch, q.r, q.c)] = 1'b1;
                REQ_WEIGHT: wgt_set[wgt_at(q.f, q.ch, q.tr, q.tc)] = 1'b1;
                REQ_BIAS:   bias_set[q.f] = 1'b1;
                default:    ;
            endcase
        pending_reqs = {pending_reqs, q};
    endtask

    // Queue a request; an in-range compute first gets every entry it reads filled
    task automatic queue_req(conv_req_t q);
        conv_req_t w;
        int k, half, rr, cc;
        if (q.req == REQ_COMPUTE && req_in_range(q)) begin
            k = eff(CFG_KERNEL);
            half = k / 2;
            if (!bias_set[q.f]) begin
                w = blank_req(REQ_BIAS);
                w.f = q.f;
                queue_write(w);
            end
            for (int p = 0; p < eff(CFG_CHANNELS); p++)
                for (int a = 0; a < k; a++)
                    for (int b = 0; b < k; b++)
                    begin
                        rr = q.r + a - half;
                        cc = q.c + b - half;
                        if (rr < 0 || rr >= eff(CFG_HEIGHT) || cc < 0 || cc >= eff(CFG_WIDTH))
                            continue;
                        if (!img_set[img_at(p, rr, cc)]) begin
                            w = blank_req(REQ_SAMPLE);
                            w.ch = 5'(p); w.r = 5'(rr); w.c = 5'(cc);
                            queue_write(w);
                        end
                        if (!wgt_set[wgt_at(q.f, p, a, b)]) begin
                            w = blank_req(REQ_WEIGHT);
                            w.f = q.f; w.ch = 5'(p); w.tr = 3'(a); w.tc = 3'(b);
                            queue_write(w);
                        end
                    end
            pending_reqs = {pending_reqs, q};
        end else begin
            queue_write(q);
        end
    endtask

    task automatic queue_compute(int f, int r, int c);
        conv_req_t q;
        q = blank_req(REQ_COMPUTE);
        q.f = 6'(f); q.r = 5'(r); q.c = 5'(c);
        queue_req(q);
    endtask

    // Mostly computes and in-range loads, the rest fully random noise
    task automatic queue_random(int n);
        conv_req_t q;
        int kind;
        for (int i = 0; i < n; i++) begin
            kind = $urandom_range(0, 9);
            q = blank_req(2'($urandom_range(0, 3)));
            q.f = 6'($urandom); q.ch = 5'($urandom); q.r = 5'($urandom); q.c = 5'($urandom);
            q.tr = 3'($urandom); q.tc = 3'($urandom);
            if (kind < 7 && eff(CFG_FILTERS) > 0 && eff(CFG_CHANNELS) > 0
                && eff(CFG_HEIGHT) > 0 && eff(CFG_WIDTH) > 0) begin
                if (kind < 4)
                    q.req = REQ_COMPUTE;
                q.f = 6'($urandom_range(0, eff(CFG_FILTERS) - 1));
                q.ch = 5'($urandom_range(0, eff(CFG_CHANNELS) - 1));
                q.r = 5'($urandom_range(0, eff(CFG_HEIGHT) - 1));
                q.c = 5'($urandom_range(0, eff(CFG_WIDTH) - 1));
                if (eff(CFG_KERNEL) > 0) begin
                    q.tr = 3'($urandom_range(0, eff(CFG_KERNEL) - 1));
                    q.tc = 3'($urandom_range(0, eff(CFG_KERNEL) - 1));
                end
            end
            queue_req(q);
        end
    endtask

    // Hold until nothing is queued, offered or in flight
    task automatic drain();
        wait (pending_reqs.size() == 0 && expected_res.size() == 0 && !in_valid);
        repeat (20) @(negedge clk);
    endtask

    task automatic set_config(int w, int h, int nc, int nf, int k);
        int vals [5];
        vals = '{w, h, nc, nf, k};
        for (int i = 0; i < 5; i++) begin
            @(negedge clk);
            cfg_we <= 1'b1;
            cfg_addr <= 3'(i);
            cfg_wdata <= 7'(vals[i]);
            cfg_reg[i] = 7'(vals[i]);
        end
        @(negedge clk);
        cfg_we <= 1'b0;
    endtask

    // Request driver
    conv_req_t cur_req;
    bit        req_taken = 1'b0;
    int        send_gap = 0;
    bit        send_burst = 1'b0;

    always @(posedge clk)
    begin
        if (rst_n && in_valid && !in_stall) begin
            expected_res = {expected_res, conv_predict(cur_req)};
            req_taken = 1'b1;
        end
    end

    always @(negedge clk)
    begin
        if (rst_n && !(in_valid && !req_taken)) begin
            if (req_taken) begin
                req_taken = 1'b0;
                if ($urandom_range(0, 40) == 0)
                    send_burst = !send_burst;
                send_gap = send_burst ? 0 : $urandom_range(0, 15);
            end
            if (send_gap > 0) begin
                send_gap--;
                in_valid <= 1'b0;
            end else if (pending_reqs.size() > 0) begin
                cur_req = pending_reqs.pop_front();
                req_type <= cur_req.req;
                filter_index <= cur_req.f;
                channel <= cur_req.ch;
                row <= cur_req.r;
                col <= cur_req.c;
                tap_row <= cur_req.tr;
                tap_col <= cur_req.tc;
                sample_value <= cur_req.sv;
                bias_value <= cur_req.bv;
                in_valid <= 1'b1;
            end else begin
                in_valid <= 1'b0;
            end
        end
    end

    // Result monitor
    int  hold_cnt = 0;
    bit  hold_burst = 1'b0;
    conv_res_t exp_res;

    always @(negedge clk)
    begin
        if (hold_cnt > 0) begin
            hold_cnt--;
            out_stall <= 1'b1;
        end else begin
            out_stall <= 1'b0;
        end
    end

    always @(posedge clk)
    begin
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("TB_ERROR");
            $finish;
        end
        if (rst_n && out_valid && !out_stall) begin
            if (expected_res.size() == 0) begin
                $error("unexpected result conv_out=%0d", conv_out);
                err_count++;
            end else begin
                exp_res = expected_res.pop_front();
                if (conv_out !== exp_res.val) begin
                    $error("conv_out expected %0d actual %0d", exp_res.val, conv_out);
                    err_count++;
                end
                if (saturated !== exp_res.sat) begin
                    $error("saturated expected %0d actual %0d", exp_res.sat, saturated);
                    err_count++;
                end
                if (bad_index !== exp_res.bad) begin
                    $error("bad_index expected %0d actual %0d", exp_res.bad, bad_index);
                    err_count++;
                end
            end
            if ($urandom_range(0, 40) == 0)
                hold_burst = !hold_burst;
            hold_cnt = hold_burst ? 0 : $urandom_range(0, 15);
        end
    end

    initial
    begin
        conv_req_t q;
        cfg_reg = '{7'd32, 7'd32, 7'd3, 7'd32, 7'd3};
        for (int i = 0; i < MC*MH*MW; i++) begin img_mem[i] = 0; img_set[i] = 0; end
        for (int i = 0; i < MF*MC*MK*MK; i++) begin wgt_mem[i] = 0; wgt_set[i] = 0; end
        for (int i = 0; i < MF; i++) begin bias_mem[i] = 0; bias_set[i] = 0; end
        repeat (12) @(negedge clk);
        rst_n <= 1'b1;

        // Reset sizes: out-of-range loads, extreme bias loads, an out-of-range compute, then corner computes
        q = blank_req(REQ_SAMPLE); q.ch = 5'd3; queue_req(q);
        q = blank_req(REQ_WEIGHT); q.tr = 3'd3; queue_req(q);
        q = blank_req(REQ_WEIGHT); q.f = 6'd32; q.tc = 3'd7; queue_req(q);
        q = blank_req(REQ_BIAS); q.f = 6'd32; queue_req(q);
        q = blank_req(REQ_BIAS); q.f = 6'd1; q.bv = 32'sh7fffffff; queue_req(q);
        q = blank_req(REQ_BIAS); q.f = 6'd2; q.bv = 32'sh80000000; queue_req(q);
        q = blank_req(REQ_COMPUTE); q.f = 6'd63; queue_req(q);
        queue_compute(0, 0, 0);
        queue_compute(31, 31, 31);
        queue_compute(1, 0, 31);
        queue_compute(2, 31, 0);
        drain();

        set_config(4, 3, 2, 5, 3);
        queue_random(60);
        drain();

        set_config(1, 1, 1, 1, 1);
        queue_random(40);
        drain();

        // Oversized width and filter count saturate to the store limits
        set_config(63, 2, 2, 127, 2);
        queue_compute(63, 1, 31);
        drain();

        // Oversized channel count and kernel side saturate as well
        set_config(1, 1, 63, 2, 7);
        queue_compute(1, 0, 0);
        drain();

        // Zero sizes reject everything
        set_config(0, 0, 0, 0, 0);
        queue_random(20);
        drain();

        // Zero kernel: compute returns the bias alone
        set_config(5, 5, 4, 8, 0);
        queue_random(40);
        drain();

        set_config(5, 4, 1, 2, 5);
        queue_random(40);
        drain();

        set_config(7, 9, 1, 4, 2);
        queue_random(40);
        drain();

        set_config(3, 2, 1, 3, 4);
        queue_random(40);
        drain();

        if (err_count == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end
endmodule

// File: multichannel_conv2d_same_bias_top.f
+incdir+design
design/mcconv_pkg.sv
design/mcconv_ctrl.sv
design/mcconv_dp.sv
design/multichannel_conv2d_same_bias_top.sv
sim/multichannel_conv2d_same_bias_top_tb.sv
